@@ rtl/core/apqs_pkg.sv @@
// ----------------------------------------------------------------------------
// apqs_pkg
// Shared types, widths and codes for the aging priority queue selector.
// ----------------------------------------------------------------------------
package apqs_pkg;

    localparam int ID_W           = 16;
    localparam int TIME_W         = 32;
    localparam int THR_W          = 16;
    localparam int STATUS_W       = 2;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam logic [THR_W-1:0] THRESH_RESET = 16'd6000;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic PRIO_LOW  = 1'b0;
    localparam logic PRIO_HIGH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              prio;
        logic [TIME_W-1:0] arrival;
    } entry_t;

    typedef struct packed {
        logic    load_item;
        logic    push_wr;
        logic    res_set;
        status_t res_code;
        logic    scan_start;
        logic    scan_rd;
        logic    pick;
        logic    shift_rd;
        logic    finish;
        logic    emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic scan_last;
        logic shift_end;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/apqs_if.sv @@
// ----------------------------------------------------------------------------
// apqs_req_if / apqs_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface apqs_req_if
    import apqs_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ID_W-1:0]   packet_id;
    logic              priority_req;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, output req_type, output packet_id,
                    output priority_req, output now_time, input ready);
    modport sink   (input valid, input req_type, input packet_id,
                    input priority_req, input now_time, output ready);
endinterface

interface apqs_rsp_if
    import apqs_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     out_packet_id;
    logic                out_priority;
    logic                promoted;

    modport source (output valid, output status, output out_packet_id,
                    output out_priority, output promoted, input ready);
    modport sink   (input valid, input status, input out_packet_id,
                    input out_priority, input promoted, output ready);
endinterface

@@ rtl/core/apqs_ctrl.sv @@
// ----------------------------------------------------------------------------
// apqs_ctrl
// Sequencer: decode, queue scan, pick, compaction and result hand-off.
// ----------------------------------------------------------------------------
module apqs_ctrl
    import apqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_PICK,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        cmd.res_code = STATUS_OK;
        state_next = state_reg;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!status.is_pop)
                begin
                    cmd.res_set = 1'b1;
                    if (status.full)
                    begin
                        cmd.res_code = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.push_wr  = 1'b1;
                        cmd.res_code = STATUS_OK;
                    end
                    state_next = ST_EMIT;
                end
                else if (status.empty)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STATUS_EMPTY;
                    state_next   = ST_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (status.shift_end)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/apqs_datapath.sv @@
// ----------------------------------------------------------------------------
// apqs_datapath
// Queue memory, scan trackers, compaction pipe and result register.
// ----------------------------------------------------------------------------
module apqs_datapath
    import apqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    input  logic                cfg_we,
    input  logic [THR_W-1:0]    cfg_wdata,
    input  logic                req_type,
    input  logic [ID_W-1:0]     packet_id,
    input  logic                priority_req,
    input  logic [TIME_W-1:0]   now_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [ID_W-1:0]     out_packet_id,
    output logic                out_priority,
    output logic                out_promoted
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    entry_t mem [QUEUE_DEPTH];

    logic              item_kind_reg;
    logic [ID_W-1:0]   item_id_reg;
    logic              item_prio_reg;
    logic [TIME_W-1:0] item_now_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [THR_W-1:0]  thr_reg;

    logic [IDX_W-1:0]  scan_idx_reg;
    logic              rd_pend_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    entry_t            rd_data_reg;

    logic              aged_found_reg;
    logic [IDX_W-1:0]  aged_idx_reg;
    logic [ID_W-1:0]   aged_id_reg;
    logic              high_found_reg;
    logic [IDX_W-1:0]  high_idx_reg;
    logic [ID_W-1:0]   high_id_reg;
    logic [ID_W-1:0]   head_id_reg;

    logic [IDX_W-1:0]  shift_idx_reg;
    logic              wr_pend_reg;
    logic [IDX_W-1:0]  wr_addr_reg;

    status_t           res_status_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_prio_reg;
    logic              res_promo_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic                out_prio_reg;
    logic                out_promo_reg;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  shift_src;
    logic [TIME_W-1:0] age;
    logic              aged_hit;
    logic              high_hit;
    logic [IDX_W-1:0]  pick_idx;
    entry_t            push_entry;

    assign shift_src = shift_idx_reg + IDX_W'(1);
    assign rd_en     = cmd.scan_rd | cmd.shift_rd;
    assign rd_addr   = cmd.scan_rd ? scan_idx_reg : shift_src;

    assign age      = item_now_reg - rd_data_reg.arrival;
    assign aged_hit = rd_pend_reg && (rd_data_reg.prio == PRIO_LOW) &&
                      (age >= {{(TIME_W-THR_W){1'b0}}, thr_reg});
    assign high_hit = rd_pend_reg && (rd_data_reg.prio == PRIO_HIGH);

    assign pick_idx = aged_found_reg ? aged_idx_reg :
                      (high_found_reg ? high_idx_reg : '0);

    assign push_entry = '{id: item_id_reg, prio: item_prio_reg, arrival: item_now_reg};

    assign status.is_pop    = (item_kind_reg == REQ_POP);
    assign status.full      = (count_reg == DEPTH_C);
    assign status.empty     = (count_reg == '0);
    assign status.scan_last = ({{(CNT_W-IDX_W){1'b0}}, scan_idx_reg} == count_reg - CNT_W'(1));
    assign status.shift_end = ({{(CNT_W-IDX_W){1'b0}}, shift_idx_reg} + CNT_W'(1) >= count_reg);
    assign status.out_free  = !out_valid_reg || out_ready;

    // queue storage: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.push_wr)
        begin
            mem[count_reg[IDX_W-1:0]] <= push_entry;
        end
        else if (wr_pend_reg)
        begin
            mem[wr_addr_reg] <= rd_data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            thr_reg        <= THRESH_RESET;
            rd_pend_reg    <= 1'b0;
            wr_pend_reg    <= 1'b0;
            aged_found_reg <= 1'b0;
            high_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (cmd.push_wr)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            rd_pend_reg <= cmd.scan_rd;
            wr_pend_reg <= cmd.shift_rd;
            if (cmd.scan_start)
            begin
                aged_found_reg <= 1'b0;
                high_found_reg <= 1'b0;
            end
            else
            begin
                if (aged_hit)
                begin
                    aged_found_reg <= 1'b1;
                end
                if (high_hit)
                begin
                    high_found_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_kind_reg <= req_type;
            item_id_reg   <= packet_id;
            item_prio_reg <= priority_req;
            item_now_reg  <= now_time;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
        end
        else if (cmd.scan_rd)
        begin
            scan_idx_reg <= scan_idx_reg + IDX_W'(1);
        end
        if (cmd.scan_rd)
        begin
            rd_idx_reg <= scan_idx_reg;
        end
        if (aged_hit && !aged_found_reg)
        begin
            aged_idx_reg <= rd_idx_reg;
            aged_id_reg  <= rd_data_reg.id;
        end
        if (high_hit && !high_found_reg)
        begin
            high_idx_reg <= rd_idx_reg;
            high_id_reg  <= rd_data_reg.id;
        end
        if (rd_pend_reg && (rd_idx_reg == '0))
        begin
            head_id_reg <= rd_data_reg.id;
        end
        if (cmd.pick)
        begin
            shift_idx_reg <= pick_idx;
        end
        else if (cmd.shift_rd)
        begin
            shift_idx_reg <= shift_src;
        end
        if (cmd.shift_rd)
        begin
            wr_addr_reg <= shift_idx_reg;
        end
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_code;
            res_id_reg     <= '0;
            res_prio_reg   <= 1'b0;
            res_promo_reg  <= 1'b0;
        end
        else if (cmd.pick)
        begin
            res_status_reg <= STATUS_OK;
            res_promo_reg  <= aged_found_reg;
            if (aged_found_reg)
            begin
                res_id_reg   <= aged_id_reg;
                res_prio_reg <= PRIO_LOW;
            end
            else if (high_found_reg)
            begin
                res_id_reg   <= high_id_reg;
                res_prio_reg <= PRIO_HIGH;
            end
            else
            begin
                res_id_reg   <= head_id_reg;
                res_prio_reg <= PRIO_LOW;
            end
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_prio_reg   <= res_prio_reg;
            out_promo_reg  <= res_promo_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_packet_id = out_id_reg;
    assign out_priority  = out_prio_reg;
    assign out_promoted  = out_promo_reg;

endmodule

@@ rtl/core/aging_priority_queue_select.sv @@
// ----------------------------------------------------------------------------
// aging_priority_queue_select
// Arrival-ordered packet queue with two priority levels and aging promotion.
// ----------------------------------------------------------------------------
// One request beat at a time. A push, or a pop of an empty queue, goes from
// accept through the decide state to the emit state, which waits for a free
// output register. A pop of a queue holding n entries, removing the entry at
// position p, uses the single read port of the queue memory once per entry
// for the scan and once per moved entry for compaction. The next request is
// accepted as soon as the result sits in the output register.
// Queue memory is not cleared; only entries below the fill count are read.
// ----------------------------------------------------------------------------
module aging_priority_queue_select
    import apqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    apqs_req_if.sink         req,
    apqs_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    apqs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (dp_status),
        .cmd       (cmd)
    );

    apqs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (dp_status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req_type      (req.req_type),
        .packet_id     (req.packet_id),
        .priority_req  (req.priority_req),
        .now_time      (req.now_time),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_status    (rsp.status),
        .out_packet_id (rsp.out_packet_id),
        .out_priority  (rsp.out_priority),
        .out_promoted  (rsp.promoted)
    );

endmodule
